// ===== rtl/assert_macros.svh =====
// Assertion shorthands used by the checker in bbps_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBPS_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BBPS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/bbps_pkg.sv =====
package bbps_pkg;

    // Field widths.
    localparam int VAL_W         = 24;
    localparam int POS_IN_W      = 23;
    localparam int GRAV_W        = 16;
    localparam int FACTOR_W      = 9;
    localparam int AREA_W        = 7;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int FRAC_BITS_DEF = 16;

    // Register reset values.
    localparam logic [GRAV_W-1:0]   GRAV_RST   = 16'd714;
    localparam logic [FACTOR_W-1:0] FACTOR_RST = 9'd205;
    localparam logic [AREA_W-1:0]   WIDTH_RST  = 7'd40;
    localparam logic [AREA_W-1:0]   HEIGHT_RST = 7'd20;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNCE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRICTION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd4;

    // Command codes.
    localparam logic CMD_FRAME   = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef struct packed {
        logic [GRAV_W-1:0]   gravity_step;
        logic [FACTOR_W-1:0] bounciness;
        logic [FACTOR_W-1:0] friction;
        logic [AREA_W-1:0]   box_width;
        logic [AREA_W-1:0]   box_height;
    } bbps_cfg_t;

    typedef struct packed {
        logic                     command;
        logic [POS_IN_W-1:0]      start_x;
        logic [POS_IN_W-1:0]      start_y;
        logic signed [VAL_W-1:0]  start_vx;
        logic signed [VAL_W-1:0]  start_vy;
    } bbps_cmd_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] pos_x;
        logic signed [VAL_W-1:0] pos_y;
        logic signed [VAL_W-1:0] vel_x;
        logic signed [VAL_W-1:0] vel_y;
        logic                    hit_x;
        logic                    hit_y;
    } bbps_res_t;

    typedef struct packed {
        logic                start;
        logic [VAL_W-1:0]    mag;
        logic [FACTOR_W-1:0] factor;
    } bbps_mul_req_t;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] prod;
    } bbps_mul_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOVE,
        S_WALL,
        S_REFL,
        S_MUL_GO,
        S_MUL_WAIT,
        S_GRAV,
        S_DONE
    } bbps_seq_state_t;

endpackage

// ===== rtl/bbps_if.sv =====
// Command channel: one beat starts a frame or a restart.
interface bbps_cmd_if;
    import bbps_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    command;
    logic [POS_IN_W-1:0]     start_x;
    logic [POS_IN_W-1:0]     start_y;
    logic signed [VAL_W-1:0] start_vx;
    logic signed [VAL_W-1:0] start_vy;

    modport source (
        output valid, command, start_x, start_y, start_vx, start_vy,
        input  ready
    );

    modport sink (
        input  valid, command, start_x, start_y, start_vx, start_vy,
        output ready
    );
endinterface

// Result channel: one beat per command beat.
interface bbps_res_if;
    import bbps_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] pos_x;
    logic signed [VAL_W-1:0] pos_y;
    logic signed [VAL_W-1:0] vel_x;
    logic signed [VAL_W-1:0] vel_y;
    logic                    hit_x;
    logic                    hit_y;

    modport source (
        output valid, pos_x, pos_y, vel_x, vel_y, hit_x, hit_y,
        input  ready
    );

    modport sink (
        input  valid, pos_x, pos_y, vel_x, vel_y, hit_x, hit_y,
        output ready
    );
endinterface

// ===== rtl/bbps_serial_mul.sv =====
module bbps_serial_mul (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bbps_pkg::bbps_mul_req_t req,
    output bbps_pkg::bbps_mul_rsp_t rsp
);
    import bbps_pkg::*;

    localparam int CNT_W = $clog2(FACTOR_W + 1);

    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [VAL_W-1:0]    acc_reg, acc_next;
    logic [VAL_W-1:0]    mag_reg, mag_next;
    logic [FACTOR_W-1:0] mlt_reg, mlt_next;
    logic [VAL_W:0]      sum;

    // Shift-and-add, one factor bit per cycle, LSB first. Product bits shift
    // out of the accumulator into the factor register as factor bits leave.
    always_comb
    begin
        sum       = {1'b0, acc_reg} + (mlt_reg[0] ? {1'b0, mag_reg} : '0);
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        acc_next  = acc_reg;
        mag_next  = mag_reg;
        mlt_next  = mlt_reg;
        if (req.start)
        begin
            cnt_next = CNT_W'(FACTOR_W);
            acc_next = '0;
            mag_next = req.mag;
            mlt_next = req.factor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
            acc_next  = sum[VAL_W:1];
            mlt_next  = {sum[0], mlt_reg[FACTOR_W-1:1]};
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Operand and product shift registers.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mag_reg <= mag_next;
        mlt_reg <= mlt_next;
    end

    // The Q8 product is the full product without its low eight bits; it
    // always fits in VAL_W bits, so the top accumulator bit is zero.
    assign rsp.done = done_reg;
    assign rsp.prod = {acc_reg[VAL_W-2:0], mlt_reg[FACTOR_W-1]};

endmodule

// ===== rtl/bbps_frame_seq.sv =====
module bbps_frame_seq #(
    parameter int FRAC_BITS = bbps_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bbps_pkg::bbps_cfg_t cfg,
    input  logic                start,
    input  bbps_pkg::bbps_cmd_t cmd_in,
    input  logic                out_free,
    output logic                idle,
    output logic                load,
    output bbps_pkg::bbps_res_t result
);
    import bbps_pkg::*;

    // Working width: wide enough for twice the far wall minus a position.
    localparam int CW = ((FRAC_BITS + 8 > VAL_W) ? FRAC_BITS + 8 : VAL_W) + 2;

    localparam logic signed [CW-1:0] LO_W  = {{(CW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic signed [CW-1:0] TWO_W = {{(CW-2){1'b0}}, 2'b10};
    localparam logic signed [CW-1:0] MAX_W = {{(CW-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    localparam logic signed [CW-1:0] MIN_W = {{(CW-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

    localparam logic signed [VAL_W-1:0] BX_RST = VAL_W'(1 << FRAC_BITS);
    localparam logic signed [VAL_W-1:0] BY_RST = VAL_W'(5 << FRAC_BITS);
    localparam logic signed [VAL_W-1:0] VX_RST = VAL_W'(1 << FRAC_BITS);
    localparam logic signed [VAL_W-1:0] VY_RST = -VAL_W'((1 << FRAC_BITS) / 3);

    bbps_seq_state_t state_reg, state_next;

    logic signed [VAL_W-1:0] bx_reg, bx_next;
    logic signed [VAL_W-1:0] by_reg, by_next;
    logic signed [VAL_W-1:0] vx_reg, vx_next;
    logic signed [VAL_W-1:0] vy_reg, vy_next;
    logic                    hx_reg, hx_next;
    logic                    hy_reg, hy_next;
    logic                    axis_reg, axis_next;
    logic                    phase_reg, phase_next;

    logic signed [CW-1:0]    size_w, p_w, hi_w, refl_w;
    logic signed [CW-1:0]    sum_x, sum_y, grav_sum, prod_w, scaled_w;
    logic signed [VAL_W-1:0] src;
    logic                    neg;
    logic                    bounce;
    logic                    mul_go;
    bbps_mul_req_t           mul_req;
    bbps_mul_rsp_t           mul_rsp;

    function automatic logic signed [CW-1:0] ext(input logic signed [VAL_W-1:0] v);
        return {{(CW-VAL_W){v[VAL_W-1]}}, v};
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [CW-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > MAX_W)
            r = MAX_W[VAL_W-1:0];
        else if (v < MIN_W)
            r = MIN_W[VAL_W-1:0];
        else
            r = v[VAL_W-1:0];
        return r;
    endfunction

    // Damping multiplier, shared by every velocity scaling.
    bbps_serial_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // Arithmetic for the current axis and multiplier phase.
    always_comb
    begin
        size_w = $signed({{(CW-AREA_W){1'b0}},
                          (axis_reg ? cfg.box_height : cfg.box_width)});
        p_w    = ext(axis_reg ? by_reg : bx_reg);
        hi_w   = (size_w - TWO_W) <<< FRAC_BITS;
        bounce = (p_w < LO_W) || (p_w > hi_w);

        // Reflection: below the low wall mirrors about it; exactly on it
        // (with the walls crossed) adds the overshoot past the high wall.
        if (p_w < LO_W)
            refl_w = (LO_W <<< 1) - p_w;
        else if (p_w == LO_W)
            refl_w = LO_W + p_w - hi_w;
        else
            refl_w = (hi_w <<< 1) - p_w;

        sum_y    = ext(by_reg) + ext(vy_reg)
                 + $signed({{(CW-GRAV_W+1){1'b0}}, cfg.gravity_step[GRAV_W-1:1]});
        sum_x    = ext(bx_reg) + ext(vx_reg);
        grav_sum = ext(vy_reg) + $signed({{(CW-GRAV_W){1'b0}}, cfg.gravity_step});

        // Phase 0 scales the normal velocity (negated), phase 1 the tangent.
        src = (axis_reg == phase_reg) ? vx_reg : vy_reg;
        neg = phase_reg ? src[VAL_W-1] : (!src[VAL_W-1] && (src != '0));

        mul_req.start  = mul_go;
        mul_req.mag    = src[VAL_W-1] ? unsigned'(-src) : unsigned'(src);
        mul_req.factor = phase_reg ? cfg.friction : cfg.bounciness;

        prod_w   = $signed({{(CW-VAL_W){1'b0}}, mul_rsp.prod});
        scaled_w = neg ? -prod_w : prod_w;
    end

    // Sequencer: next state, next data and strobes.
    always_comb
    begin
        state_next = state_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        hx_next    = hx_reg;
        hy_next    = hy_reg;
        axis_next  = axis_reg;
        phase_next = phase_reg;
        mul_go     = 1'b0;
        load       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd_in.command == CMD_RESTART)
                    begin
                        bx_next    = {1'b0, cmd_in.start_x};
                        by_next    = {1'b0, cmd_in.start_y};
                        vx_next    = cmd_in.start_vx;
                        vy_next    = cmd_in.start_vy;
                        hx_next    = 1'b0;
                        hy_next    = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MOVE;
                    end
                end
            end
            S_MOVE:
            begin
                by_next    = sat_val(sum_y);
                bx_next    = sat_val(sum_x);
                hx_next    = 1'b0;
                hy_next    = 1'b0;
                axis_next  = 1'b0;
                state_next = S_WALL;
            end
            S_WALL:
            begin
                if (bounce)
                begin
                    if (axis_reg)
                        hy_next = 1'b1;
                    else
                        hx_next = 1'b1;
                    state_next = S_REFL;
                end
                else if (!axis_reg)
                begin
                    axis_next = 1'b1;
                end
                else
                begin
                    state_next = S_GRAV;
                end
            end
            S_REFL:
            begin
                if (axis_reg)
                    by_next = sat_val(refl_w);
                else
                    bx_next = sat_val(refl_w);
                phase_next = 1'b0;
                state_next = S_MUL_GO;
            end
            S_MUL_GO:
            begin
                mul_go     = 1'b1;
                state_next = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    if (axis_reg == phase_reg)
                        vx_next = sat_val(scaled_w);
                    else
                        vy_next = sat_val(scaled_w);
                    if (!phase_reg)
                    begin
                        phase_next = 1'b1;
                        state_next = S_MUL_GO;
                    end
                    else if (!axis_reg)
                    begin
                        axis_next  = 1'b1;
                        state_next = S_WALL;
                    end
                    else
                    begin
                        state_next = S_GRAV;
                    end
                end
            end
            S_GRAV:
            begin
                vy_next    = sat_val(grav_sum);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Ball state and step flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bx_reg    <= BX_RST;
            by_reg    <= BY_RST;
            vx_reg    <= VX_RST;
            vy_reg    <= VY_RST;
            hx_reg    <= 1'b0;
            hy_reg    <= 1'b0;
            axis_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            bx_reg    <= bx_next;
            by_reg    <= by_next;
            vx_reg    <= vx_next;
            vy_reg    <= vy_next;
            hx_reg    <= hx_next;
            hy_reg    <= hy_next;
            axis_reg  <= axis_next;
            phase_reg <= phase_next;
        end
    end

    assign idle         = (state_reg == S_IDLE);
    assign result.pos_x = bx_reg;
    assign result.pos_y = by_reg;
    assign result.vel_x = vx_reg;
    assign result.vel_y = vy_reg;
    assign result.hit_x = hx_reg;
    assign result.hit_y = hy_reg;

endmodule

// ===== rtl/bouncing_ball_physics_step_core.sv =====
// One command beat gives one result beat. A restart is registered in the
// sequencer, then loaded into the output register once that is free. A frame
// moves the ball, checks each axis against its walls, adds gravity and loads
// the result; an axis that bounces adds a position reflection and two runs of
// the bit-serial damping multiplier (normal and tangent velocity), each with
// a start step and a write-back. The multiplier consumes one bit of the 9-bit
// factor per cycle, which sets the bounce cost. The block takes a new command
// as soon as the sequencer is idle, while the previous result may still wait
// in the output register; a finished result waits inside the sequencer only
// while that register is full. Configuration writes take effect on the next
// frame if the user writes only while idle; the block does not enforce it.
module bouncing_ball_physics_step_core #(
    parameter int FRAC_BITS = bbps_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bbps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bbps_pkg::CFG_DATA_W-1:0]     cfg_data,
    bbps_cmd_if.sink                            cmd,
    bbps_res_if.source                          res
);
    import bbps_pkg::*;

    bbps_cfg_t cfg_reg;
    bbps_cmd_t cmd_beat;
    bbps_res_t seq_result;
    bbps_res_t res_reg;
    logic      res_valid_reg;
    logic      seq_idle;
    logic      seq_load;
    logic      out_free;
    logic      start;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gravity_step <= GRAV_RST;
            cfg_reg.bounciness   <= FACTOR_RST;
            cfg_reg.friction     <= FACTOR_RST;
            cfg_reg.box_width    <= WIDTH_RST;
            cfg_reg.box_height   <= HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRAVITY:  cfg_reg.gravity_step <= cfg_data[GRAV_W-1:0];
                REG_BOUNCE:   cfg_reg.bounciness   <= cfg_data[FACTOR_W-1:0];
                REG_FRICTION: cfg_reg.friction     <= cfg_data[FACTOR_W-1:0];
                REG_WIDTH:    cfg_reg.box_width    <= cfg_data[AREA_W-1:0];
                REG_HEIGHT:   cfg_reg.box_height   <= cfg_data[AREA_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Command side.
    assign cmd.ready         = seq_idle;
    assign start             = cmd.valid && seq_idle;
    assign cmd_beat.command  = cmd.command;
    assign cmd_beat.start_x  = cmd.start_x;
    assign cmd_beat.start_y  = cmd.start_y;
    assign cmd_beat.start_vx = cmd.start_vx;
    assign cmd_beat.start_vy = cmd.start_vy;

    bbps_frame_seq #(
        .FRAC_BITS (FRAC_BITS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .start    (start),
        .cmd_in   (cmd_beat),
        .out_free (out_free),
        .idle     (seq_idle),
        .load     (seq_load),
        .result   (seq_result)
    );

    // Output register: holds one finished beat until it is taken.
    assign out_free = !res_valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (seq_load)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (seq_load)
            res_reg <= seq_result;
    end

    assign res.valid = res_valid_reg;
    assign res.pos_x = res_reg.pos_x;
    assign res.pos_y = res_reg.pos_y;
    assign res.vel_x = res_reg.vel_x;
    assign res.vel_y = res_reg.vel_y;
    assign res.hit_x = res_reg.hit_x;
    assign res.hit_y = res_reg.hit_y;

endmodule

// ===== rtl/bbps_checker.sv =====
`include "assert_macros.svh"

module bbps_checker (
    input  logic        clk,
    input  logic        rst_n,
    bbps_cmd_if.sink    cmd,
    bbps_res_if.source  res
);
    import bbps_pkg::*;

    logic [1:0]             pend_reg, pend_next;
    logic                   cmd_acc;
    logic                   res_acc;
    logic [4*VAL_W+1:0]     res_beat;

    assign cmd_acc  = cmd.valid && cmd.ready;
    assign res_acc  = res.valid && res.ready;
    assign res_beat = {res.pos_x, res.pos_y, res.vel_x, res.vel_y, res.hit_x, res.hit_y};

    // Beats accepted whose result has not yet been taken.
    always_comb
    begin
        pend_next = pend_reg;
        if (cmd_acc && !res_acc)
            pend_next = pend_reg + 1'b1;
        else if (!cmd_acc && res_acc)
            pend_next = pend_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    // A stalled result beat stays put.
    `BBPS_ASSERT_NEXT(a_res_hold, clk, rst_n, res.valid && !res.ready, res.valid && $stable(res_beat), "result beat changed while stalled")

    // One command at a time: the sequencer is busy right after a beat.
    `BBPS_ASSERT_NEXT(a_cmd_gap, clk, rst_n, cmd_acc, !cmd.ready, "command taken on consecutive cycles")

    // Every result belongs to an accepted command.
    `BBPS_ASSERT_SAME(a_no_phantom, clk, rst_n, res.valid, pend_reg != 2'd0, "result without a command")

    // At most one finished result waits while a new command is taken.
    `BBPS_ASSERT_SAME(a_bounded, clk, rst_n, cmd_acc, pend_reg < 2'd2, "too many commands in flight")

endmodule

bind bouncing_ball_physics_step_core bbps_checker u_bbps_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .res   (res)
);
